// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LKVC_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lkvc assertion failed");

// If the antecedent holds, the consequent must hold in the next cycle.
`define LKVC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

// ===== rtl/lkvc_pkg.sv =====
// Package with the shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int CAPACITY      = 8;
    localparam int KEY_WIDTH     = 32;
    localparam int VALUE_W       = 32;
    localparam int CFG_W         = 4;
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CFG_W-1:0] CFG_CAP_RESET = CFG_W'(8);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_HIT,
        MODE_FILL,
        MODE_EVICT
    } cell_mode_t;

    typedef struct packed {
        logic                      valid;
        logic [KEY_WIDTH-1:0]      key;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        cell_mode_t           mode;
    } cell_ctl_t;

    typedef struct packed {
        logic match;
        logic last;
    } cell_stat_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: a recency-ordered chain of entry cells.
//
//  Channel   Direction  Accept when          Contents
//  s_        in         s_tvalid & s_tready  tuser: cmd; tdata: lookup_key, write_value
//  m_        out        m_tvalid & m_tready  tuser: hit, evicted, nonempty;
//                                            tdata: read_value, evicted_key, most_recent_key
//  cfg_      in         cfg_we               capacity_in_use
//
// One request is taken per cycle while no result is stalled; its result is registered
// and shows in the next cycle. The cycle is set by the key compare in every cell and the
// shift enable that ripples along the chain of CAPACITY cells. Reset empties the cache at
// once, with no clearing pass. A stalled result holds the input off only until it is taken.
`timescale 1ns / 1ps

module lru_key_value_cache (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // lookup_key, write_value
    input  logic [0:0]                  s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [95:0]                 m_tdata,   // read_value, evicted_key, most_recent_key
    output logic [2:0]                  m_tuser    // hit, evicted, nonempty
);

    localparam int N  = lkvc_pkg::CAPACITY;
    localparam int KW = lkvc_pkg::KEY_WIDTH;
    localparam int VW = lkvc_pkg::VALUE_W;

    logic [lkvc_pkg::CFG_W-1:0] cap_reg;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [95:0]                m_tdata_reg, m_tdata_next;
    logic [2:0]                 m_tuser_reg, m_tuser_next;

    logic                       s_fire;
    logic                       is_lookup;
    logic [KW-1:0]              req_key;
    logic signed [VW-1:0]       req_value;
    logic [lkvc_pkg::IDX_W-1:0] cap_idx;
    logic [N-1:0]               valid_vec;
    logic                       full;
    logic                       hit_any;
    logic signed [VW-1:0]       hit_value;
    logic [KW-1:0]              last_key;
    logic                       changes;

    lkvc_pkg::cell_ctl_t        ctl;
    lkvc_pkg::entry_t           head;
    lkvc_pkg::entry_t           held [N];
    lkvc_pkg::cell_stat_t       stat [N];
    logic [N:0]                 shift;

    logic                       res_evicted;
    logic signed [VW-1:0]       res_read;
    logic [KW-1:0]              res_ev_key;
    logic [KW-1:0]              res_mrk;
    logic                       res_nonempty;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign is_lookup = (lkvc_pkg::cmd_t'(s_tuser[0]) == lkvc_pkg::CMD_LOOKUP);
    assign req_key   = s_tdata[KW-1:0];
    assign req_value = s_tdata[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lkvc_pkg::CFG_CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Zero acts as one and values above the cell count saturate.
    always_comb begin
        if (cap_reg == '0) begin
            cap_idx = '0;
        end else if (int'(cap_reg) > N) begin
            cap_idx = lkvc_pkg::IDX_W'(N - 1);
        end else begin
            cap_idx = lkvc_pkg::IDX_W'(cap_reg - lkvc_pkg::CFG_W'(1));
        end
    end

    always_comb begin
        hit_any   = 1'b0;
        hit_value = '0;
        last_key  = '0;
        for (int i = 0; i < N; i++) begin
            valid_vec[i] = held[i].valid;
            hit_any      = hit_any | stat[i].match;
            hit_value    = hit_value | (stat[i].match ? held[i].value : '0);
            last_key     = last_key | (stat[i].last ? held[i].key : '0);
        end
    end

    // Valid entries always fill the chain from position zero, so this reads count >= capacity.
    assign full = valid_vec[cap_idx];

    always_comb begin
        ctl.key = req_key;
        if (hit_any) begin
            ctl.mode = lkvc_pkg::MODE_HIT;
        end else if (full) begin
            ctl.mode = lkvc_pkg::MODE_EVICT;
        end else begin
            ctl.mode = lkvc_pkg::MODE_FILL;
        end
    end

    assign changes    = hit_any || !is_lookup;
    assign shift[0]   = s_fire && changes;
    assign head.valid = 1'b1;
    assign head.key   = req_key;
    assign head.value = is_lookup ? hit_value : req_value;

    for (genvar g = 0; g < N; g++) begin : g_cell
        lkvc_pkg::entry_t left;
        logic             right_valid;

        if (g == 0) begin : g_first
            assign left = head;
        end else begin : g_inner
            assign left = held[g-1];
        end

        if (g == N - 1) begin : g_end
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right_valid = held[g+1].valid;
        end

        lkvc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .shift_in    (shift[g]),
            .left        (left),
            .right_valid (right_valid),
            .shift_out   (shift[g+1]),
            .held        (held[g]),
            .stat        (stat[g])
        );
    end

    assign res_evicted  = !is_lookup && !hit_any && full;
    assign res_read     = (is_lookup && hit_any) ? hit_value : '0;
    assign res_ev_key   = res_evicted ? last_key : '0;
    assign res_mrk      = changes ? req_key : (held[0].valid ? held[0].key : '0);
    assign res_nonempty = changes || held[0].valid;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (s_fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {32'(res_mrk), 32'(res_ev_key), 32'(res_read)};
            m_tuser_next  = {res_nonempty, res_evicted, hit_any};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/lkvc_cell.sv =====
// One recency position of the cache: holds an entry and shifts it on to the next position.
`timescale 1ns / 1ps

module lkvc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkvc_pkg::cell_ctl_t ctl,
    input  logic                shift_in,
    input  lkvc_pkg::entry_t    left,
    input  logic                right_valid,
    output logic                shift_out,
    output lkvc_pkg::entry_t    held,
    output lkvc_pkg::cell_stat_t stat
);

    logic                              valid_reg;
    logic [lkvc_pkg::KEY_WIDTH-1:0]    key_reg;
    logic signed [lkvc_pkg::VALUE_W-1:0] value_reg;
    logic                              stop;

    assign held.valid = valid_reg;
    assign held.key   = key_reg;
    assign held.value = value_reg;

    assign stat.match = valid_reg && (key_reg == ctl.key);
    assign stat.last  = valid_reg && !right_valid;

    // The entry at the chosen position is overwritten from the left and stops the shift.
    always_comb begin
        case (ctl.mode)
            lkvc_pkg::MODE_HIT:   stop = stat.match;
            lkvc_pkg::MODE_EVICT: stop = stat.last;
            lkvc_pkg::MODE_FILL:  stop = !valid_reg;
            default:              stop = 1'b1;
        endcase
    end

    assign shift_out = shift_in && !stop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_in) begin
            valid_reg <= left.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_in) begin
            key_reg   <= left.key;
            value_reg <= left.value;
        end
    end

endmodule

// ===== rtl/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lkvc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [95:0]                m_tdata,
    input logic [2:0]                 m_tuser
);

    // A held result must not change while it waits.
    `LKVC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // Every accepted request gives a result in the following cycle.
    `LKVC_ASSERT_NEXT(a_result, aclk, aresetn, s_tvalid && s_tready, m_tvalid)
    // An eviction only follows a miss, and its key is zero otherwise.
    `LKVC_ASSERT(a_evict_miss, aclk, aresetn, !(m_tvalid && m_tuser[1] && m_tuser[0]))
    `LKVC_ASSERT(a_evict_key, aclk, aresetn, !(m_tvalid && !m_tuser[1] && (m_tdata[63:32] != 32'd0)))
    // A hit or an eviction leaves the cache holding at least one entry.
    `LKVC_ASSERT(a_nonempty, aclk, aresetn, !(m_tvalid && (m_tuser[0] || m_tuser[1]) && !m_tuser[2]))

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
